// ===== hdl/rmedf_pkg.sv =====
package rmedf_pkg;

  localparam int MAX_TASK_ENTRIES_C = 8;
  localparam int TIME_BITS_C = 32;
  localparam int COUNT_BITS_C = 16;

  // cell select field covers the largest supported row of 32 entries
  localparam int SEL_W = 5;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_FINISH = 2'd2;

  localparam logic [1:0] KIND_SEG = 2'd0;
  localparam logic [1:0] KIND_CNT = 2'd1;
  localparam logic [1:0] KIND_LOAD = 2'd2;

  localparam logic [1:0] TAG_NONE = 2'd0;
  localparam logic [1:0] TAG_LOST = 2'd1;
  localparam logic [1:0] TAG_PREEMPT = 2'd2;
  localparam logic [1:0] TAG_FINISH = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DL_OVER_PER = 2'd1;
  localparam logic [1:0] ST_BU_OVER_DL = 2'd2;

  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_TASK_COUNT = 2'd1;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_RELEASE,
    OP_LOST_CHK,
    OP_RUN,
    OP_KILL,
    OP_CLEAR
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e            op;
    logic [SEL_W-1:0]   sel;
  } cmd_t;

  typedef struct packed {
    logic active;
    logic lost;
    logic rem_le1;
  } stat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  owner;
    logic        idle;
    logic [31:0] len;
    logic [1:0]  tag;
    logic [15:0] lost;
    logic [15:0] comp;
    logic [15:0] kill;
    logic [1:0]  status;
  } res_t;

  function automatic res_t mk_seg(input logic idle, input logic [2:0] owner,
                                  input logic [31:0] len, input logic [1:0] tag);
    res_t r;
    r = '0;
    r.kind = KIND_SEG;
    r.idle = idle;
    r.owner = idle ? 3'd0 : owner;
    r.tag = idle ? TAG_NONE : tag;
    r.len = len;
    return r;
  endfunction

endpackage

// ===== hdl/rmedf_cell.sv =====
module rmedf_cell #(
  parameter int MAX_TASK_ENTRIES = rmedf_pkg::MAX_TASK_ENTRIES_C,
  parameter int TIME_BITS = rmedf_pkg::TIME_BITS_C,
  parameter int COUNT_BITS = rmedf_pkg::COUNT_BITS_C,
  parameter int NW = $clog2(MAX_TASK_ENTRIES + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rmedf_pkg::cmd_t               cmd_i,
  input  logic [rmedf_pkg::SEL_W-1:0]   idx_i,
  input  logic [NW-1:0]                 n_i,
  input  logic                          policy_i,
  input  logic [TIME_BITS-1:0]          time_i,
  input  logic [15:0]                   period_i,
  input  logic [15:0]                   deadline_i,
  input  logic [15:0]                   burst_i,
  input  logic                          cv_i,
  input  logic [rmedf_pkg::SEL_W-1:0]   cidx_i,
  input  logic [TIME_BITS-1:0]          ckey_i,
  output logic                          cv_o,
  output logic [rmedf_pkg::SEL_W-1:0]   cidx_o,
  output logic [TIME_BITS-1:0]          ckey_o,
  output rmedf_pkg::stat_t              stat_o,
  output logic [15:0]                   lost_o,
  output logic [15:0]                   comp_o,
  output logic [15:0]                   kill_o
);
  import rmedf_pkg::*;

  logic [15:0] period_q, deadline_q, burst_q;
  logic [15:0] rem_q;
  logic [TIME_BITS-1:0] absdl_q;
  logic active_q, lost_q;
  logic [COUNT_BITS-1:0] lost_cnt_q, comp_cnt_q, kill_cnt_q;
  logic [TIME_BITS-1:0] dvd_q;
  logic [15:0] r_q;
  logic cv_q;
  logic [SEL_W-1:0] cidx_q;
  logic [TIME_BITS-1:0] ckey_q;

  logic en, me;
  logic [16:0] trial;
  logic [TIME_BITS-1:0] key;

  assign en = 6'(idx_i) < 6'(n_i);
  assign me = cmd_i.sel == idx_i;
  assign trial = {r_q, dvd_q[TIME_BITS-1]};
  assign key = policy_i ? absdl_q : TIME_BITS'(period_q);

  // payload and divider registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        if (me) begin
          period_q <= period_i;
          deadline_q <= deadline_i;
          burst_q <= burst_i;
        end
      end
      OP_DIV_START: begin
        dvd_q <= time_i;
        r_q <= '0;
      end
      OP_DIV_STEP: begin
        dvd_q <= {dvd_q[TIME_BITS-2:0], 1'b0};
        r_q <= (trial >= {1'b0, period_q}) ? 16'(trial - {1'b0, period_q}) : trial[15:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      absdl_q <= '0;
      active_q <= 1'b0;
      lost_q <= 1'b0;
      lost_cnt_q <= '0;
      comp_cnt_q <= '0;
      kill_cnt_q <= '0;
      cv_q <= 1'b0;
      cidx_q <= '0;
      ckey_q <= '0;
    end else begin
      // priority chain: an earlier cell wins ties
      if (en && active_q && (!cv_i || key < ckey_i)) begin
        cv_q <= 1'b1;
        cidx_q <= idx_i;
        ckey_q <= key;
      end else begin
        cv_q <= cv_i;
        cidx_q <= cidx_i;
        ckey_q <= ckey_i;
      end
      case (cmd_i.op)
        OP_RELEASE: begin
          if (en && period_q != '0 && r_q == '0) begin
            rem_q <= burst_q;
            absdl_q <= time_i + TIME_BITS'(deadline_q);
            active_q <= 1'b1;
          end
        end
        OP_LOST_CHK: begin
          lost_q <= en && active_q && absdl_q == time_i;
          if (en && active_q && absdl_q == time_i) begin
            active_q <= 1'b0;
            if (!(&lost_cnt_q)) lost_cnt_q <= lost_cnt_q + 1'b1;
          end
        end
        OP_RUN: begin
          if (me) begin
            if (rem_q != '0) rem_q <= rem_q - 16'd1;
            if (rem_q <= 16'd1) begin
              active_q <= 1'b0;
              if (!(&comp_cnt_q)) comp_cnt_q <= comp_cnt_q + 1'b1;
            end
          end
        end
        OP_KILL: begin
          if (en && active_q) begin
            active_q <= 1'b0;
            if (!(&kill_cnt_q)) kill_cnt_q <= kill_cnt_q + 1'b1;
          end
        end
        OP_CLEAR: begin
          rem_q <= '0;
          absdl_q <= '0;
          active_q <= 1'b0;
          lost_cnt_q <= '0;
          comp_cnt_q <= '0;
          kill_cnt_q <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign cv_o = cv_q;
  assign cidx_o = cidx_q;
  assign ckey_o = ckey_q;
  assign stat_o = '{active: active_q, lost: lost_q, rem_le1: rem_q <= 16'd1};
  assign lost_o = 16'(lost_cnt_q);
  assign comp_o = 16'(comp_cnt_q);
  assign kill_o = 16'(kill_cnt_q);

endmodule

// ===== hdl/rm_edf_tick_scheduler.sv =====
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+------------------------------------
// command  | in        | start_i && !busy_o     | mode, task_index, period, deadline,
//          |           |                        | burst
// config   | in        | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
// result   | out       | res_valid_o strobe     | kind .. last, one cycle each
//
// load: status strobed in the next cycle, busy stays low
// tick: per-cell bit-serial remainder of time by period, then release, lost check
//   and the priority chain walking all cells before the chosen task runs
// finish: one counter row a cycle for each of the n taking part entries
// reset clears all run state at once; the results cannot be stalled
module rm_edf_tick_scheduler #(
  parameter int MAX_TASK_ENTRIES = rmedf_pkg::MAX_TASK_ENTRIES_C,
  parameter int TIME_BITS = rmedf_pkg::TIME_BITS_C,
  parameter int COUNT_BITS = rmedf_pkg::COUNT_BITS_C
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  mode_i,
  input  logic [2:0]  task_index_i,
  input  logic [15:0] period_i,
  input  logic [15:0] deadline_i,
  input  logic [15:0] burst_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i,
  output logic        res_valid_o,
  output logic [1:0]  kind_o,
  output logic [2:0]  owner_index_o,
  output logic        idle_o,
  output logic [31:0] seg_length_o,
  output logic [1:0]  end_tag_o,
  output logic [15:0] lost_count_o,
  output logic [15:0] complete_count_o,
  output logic [15:0] killed_count_o,
  output logic [1:0]  status_o,
  output logic        last_o
);
  import rmedf_pkg::*;

  localparam int N = MAX_TASK_ENTRIES;
  localparam int NW = $clog2(N + 1);
  localparam int IW = (N > 1) ? $clog2(N) : 1;
  localparam int CA = $clog2(TIME_BITS + 1);
  localparam int CNTW = (CA > NW) ? CA : NW;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_REL, S_LOST, S_LCLOSE, S_SEL, S_EXEC1, S_EXEC2,
    S_FIN0, S_FINCNT, S_FCLR, S_FLUSH
  } state_e;

  state_e state_q;
  logic [CNTW-1:0] cnt_q;
  logic policy_q;
  logic [3:0] task_count_q;
  logic [NW-1:0] n_cur;
  logic [TIME_BITS-1:0] time_q;

  // open segment
  logic open_v_q, open_idle_q;
  logic [IW-1:0] open_idx_q;
  logic [31:0] open_len_q;

  // one-deep holding slot so the final result of an item can carry last
  logic pend_v_q;
  res_t pend_q;
  res_t out_q, out_d;
  logic out_v_q, out_last_q;
  logic out_v_d, out_last_d;

  cmd_t cmd;
  logic accept;
  logic [1:0] ld_status;

  // cell row
  logic cv [N+1];
  logic [SEL_W-1:0] cidx [N+1];
  logic [TIME_BITS-1:0] ckey [N+1];
  stat_t stat [N];
  logic [15:0] lost_c [N];
  logic [15:0] comp_c [N];
  logic [15:0] kill_c [N];

  logic chosen_v;
  logic [IW-1:0] chosen_idx;
  logic [31:0] len_new;
  logic push_v;
  res_t push_r;

  assign cv[0] = 1'b0;
  assign cidx[0] = '0;
  assign ckey[0] = '0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    rmedf_cell #(
      .MAX_TASK_ENTRIES(MAX_TASK_ENTRIES),
      .TIME_BITS(TIME_BITS),
      .COUNT_BITS(COUNT_BITS),
      .NW(NW)
    ) u_cell (
      .clk_i(clk_i),
      .rst_ni(rst_ni),
      .cmd_i(cmd),
      .idx_i(SEL_W'(g)),
      .n_i(n_cur),
      .policy_i(policy_q),
      .time_i(time_q),
      .period_i(period_i),
      .deadline_i(deadline_i),
      .burst_i(burst_i),
      .cv_i(cv[g]),
      .cidx_i(cidx[g]),
      .ckey_i(ckey[g]),
      .cv_o(cv[g+1]),
      .cidx_o(cidx[g+1]),
      .ckey_o(ckey[g+1]),
      .stat_o(stat[g]),
      .lost_o(lost_c[g]),
      .comp_o(comp_c[g]),
      .kill_o(kill_c[g])
    );
  end

  assign accept = start_i && !busy_o;
  assign busy_o = state_q != S_IDLE;
  assign cfg_ready_o = 1'b1;

  // task count above the row size saturates
  assign n_cur = (6'(task_count_q) > 6'(N)) ? NW'(N) : NW'(task_count_q);

  assign chosen_v = cv[N];
  assign chosen_idx = cidx[N][IW-1:0];
  assign len_new = !open_v_q ? 32'd1 :
                   (&open_len_q) ? open_len_q : open_len_q + 32'd1;

  always_comb begin
    if (deadline_i > period_i) ld_status = ST_DL_OVER_PER;
    else if (burst_i > deadline_i) ld_status = ST_BU_OVER_DL;
    else ld_status = ST_OK;
  end

  // command broadcast to the cells
  always_comb begin
    cmd = '{op: OP_NOP, sel: '0};
    case (state_q)
      S_IDLE: begin
        if (accept && mode_i == MODE_LOAD && ld_status == ST_OK &&
            6'(task_index_i) < 6'(N)) begin
          cmd = '{op: OP_LOAD, sel: SEL_W'(task_index_i)};
        end else if (accept && mode_i == MODE_TICK) begin
          cmd.op = OP_DIV_START;
        end
      end
      S_DIV: cmd.op = OP_DIV_STEP;
      S_REL: cmd.op = OP_RELEASE;
      S_LOST: cmd.op = OP_LOST_CHK;
      S_EXEC2: begin
        if (chosen_v) cmd = '{op: OP_RUN, sel: SEL_W'(chosen_idx)};
      end
      S_FIN0: cmd.op = OP_KILL;
      S_FCLR: cmd.op = OP_CLEAR;
      default: begin
      end
    endcase
  end

  // result produced this cycle, at most one
  always_comb begin
    push_v = 1'b0;
    push_r = '0;
    case (state_q)
      S_LCLOSE: begin
        if (open_v_q && !open_idle_q && stat[open_idx_q].lost) begin
          push_v = 1'b1;
          push_r = mk_seg(1'b0, 3'(open_idx_q), open_len_q, TAG_LOST);
        end
      end
      S_EXEC1: begin
        if (open_v_q && ((open_idle_q != !chosen_v) ||
                         (!open_idle_q && open_idx_q != chosen_idx))) begin
          push_v = 1'b1;
          push_r = mk_seg(open_idle_q, 3'(open_idx_q), open_len_q, TAG_PREEMPT);
        end
      end
      S_EXEC2: begin
        if (chosen_v && stat[chosen_idx].rem_le1) begin
          push_v = 1'b1;
          push_r = mk_seg(1'b0, 3'(chosen_idx), len_new, TAG_FINISH);
        end
      end
      S_FIN0: begin
        if (open_v_q) begin
          push_v = 1'b1;
          push_r = mk_seg(open_idle_q, 3'(open_idx_q), open_len_q, TAG_NONE);
        end
      end
      S_FINCNT: begin
        push_v = 1'b1;
        push_r.kind = KIND_CNT;
        push_r.owner = 3'(cnt_q[IW-1:0]);
        push_r.lost = lost_c[cnt_q[IW-1:0]];
        push_r.comp = comp_c[cnt_q[IW-1:0]];
        push_r.kill = kill_c[cnt_q[IW-1:0]];
      end
      default: begin
      end
    endcase
  end

  // output register: load status, final flush, or a held result pushed out
  always_comb begin
    out_v_d = 1'b0;
    out_last_d = 1'b0;
    out_d = out_q;
    if (state_q == S_IDLE && accept && mode_i == MODE_LOAD) begin
      out_v_d = 1'b1;
      out_last_d = 1'b1;
      out_d = '{kind: KIND_LOAD, owner: task_index_i, status: ld_status, default: '0};
    end else if (state_q == S_FLUSH && pend_v_q) begin
      out_v_d = 1'b1;
      out_last_d = 1'b1;
      out_d = pend_q;
    end else if (push_v && pend_v_q) begin
      out_v_d = 1'b1;
      out_d = pend_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      policy_q <= 1'b0;
      task_count_q <= 4'd1;
      time_q <= '0;
      open_v_q <= 1'b0;
      open_idle_q <= 1'b0;
      open_idx_q <= '0;
      open_len_q <= '0;
      pend_v_q <= 1'b0;
      pend_q <= '0;
      out_q <= '0;
      out_v_q <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      out_last_q <= out_last_d;
      out_q <= out_d;

      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_POLICY: policy_q <= cfg_data_i[0];
          REG_TASK_COUNT: task_count_q <= cfg_data_i;
          default: begin
          end
        endcase
      end

      // pending slot: a new result pushes out the held one
      if (push_v) begin
        pend_q <= push_r;
        pend_v_q <= 1'b1;
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            cnt_q <= '0;
            case (mode_i)
              MODE_TICK: state_q <= S_DIV;
              MODE_FINISH: state_q <= S_FIN0;
              default: begin
              end
            endcase
          end
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNTW'(TIME_BITS - 1)) state_q <= S_REL;
        end
        S_REL: state_q <= S_LOST;
        S_LOST: state_q <= S_LCLOSE;
        S_LCLOSE: begin
          if (push_v) open_v_q <= 1'b0;
          cnt_q <= '0;
          state_q <= S_SEL;
        end
        S_SEL: begin
          // let the chain settle through every cell
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNTW'(N - 1)) state_q <= S_EXEC1;
        end
        S_EXEC1: begin
          if (push_v) open_v_q <= 1'b0;
          state_q <= S_EXEC2;
        end
        S_EXEC2: begin
          if (!open_v_q) begin
            open_idle_q <= !chosen_v;
            open_idx_q <= chosen_idx;
          end
          open_len_q <= len_new;
          open_v_q <= !push_v;
          time_q <= time_q + 1'b1;
          state_q <= S_FLUSH;
        end
        S_FIN0: begin
          open_v_q <= 1'b0;
          cnt_q <= '0;
          state_q <= (n_cur == '0) ? S_FCLR : S_FINCNT;
        end
        S_FINCNT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNTW'(n_cur - 1'b1)) state_q <= S_FCLR;
        end
        S_FCLR: begin
          time_q <= '0;
          open_v_q <= 1'b0;
          open_len_q <= '0;
          state_q <= S_FLUSH;
        end
        S_FLUSH: begin
          if (pend_v_q) pend_v_q <= 1'b0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_valid_o = out_v_q;
  assign kind_o = out_q.kind;
  assign owner_index_o = out_q.owner;
  assign idle_o = out_q.idle;
  assign seg_length_o = out_q.len;
  assign end_tag_o = out_q.tag;
  assign lost_count_o = out_q.lost;
  assign complete_count_o = out_q.comp;
  assign killed_count_o = out_q.kill;
  assign status_o = out_q.status;
  assign last_o = out_last_q;

endmodule
